@@ sv/namm_pkg.sv @@
// package for the null-aware array min/max reducer
// holds codes, types and the compare functions; no dependencies
package namm_pkg;

	localparam logic [1:0] ACT_ELEM  = 2'd0;
	localparam logic [1:0] ACT_NULL  = 2'd1;
	localparam logic [1:0] ACT_EMPTY = 2'd2;

	localparam logic [2:0] TYPE_I8   = 3'd0;
	localparam logic [2:0] TYPE_I16  = 3'd1;
	localparam logic [2:0] TYPE_I32  = 3'd2;
	localparam logic [2:0] TYPE_I64  = 3'd3;
	localparam logic [2:0] TYPE_F32  = 3'd4;
	localparam logic [2:0] TYPE_F64  = 3'd5;
	localparam logic [2:0] TYPE_BOOL = 3'd6;

	localparam logic [0:0] REG_FIND_MAX = 1'd0;
	localparam logic [0:0] REG_ELEM_TYPE = 1'd1;

	typedef struct packed {
		logic       find_max;
		logic [2:0] elem_type;
	} cfg_t;

	typedef struct packed {
		logic [63:0] value;
		logic        is_null;
		logic        last;
		logic        marker;
	} item_t;

	function automatic logic [63:0] type_mask(input logic [2:0] t);
		logic [63:0] m;
		case (t)
			TYPE_I8:   m = 64'h0000_0000_0000_00ff;
			TYPE_I16:  m = 64'h0000_0000_0000_ffff;
			TYPE_I32:  m = 64'h0000_0000_ffff_ffff;
			TYPE_F32:  m = 64'h0000_0000_ffff_ffff;
			TYPE_BOOL: m = 64'h0000_0000_0000_0001;
			default:   m = '1;
		endcase
		return m;
	endfunction

	// signed order key, compared unsigned
	function automatic logic [63:0] int_key(input logic [63:0] b, input logic [2:0] t);
		logic [63:0] v;
		case (t)
			TYPE_I8:   v = {{56{b[7]}}, b[7:0]};
			TYPE_I16:  v = {{48{b[15]}}, b[15:0]};
			TYPE_I32:  v = {{32{b[31]}}, b[31:0]};
			TYPE_BOOL: v = {63'd0, b[0]} ^ 64'h8000_0000_0000_0000;
			default:   v = b;
		endcase
		return v ^ 64'h8000_0000_0000_0000;
	endfunction

	// real order key: sign-magnitude to unsigned, -0 and +0 made equal
	function automatic logic [63:0] real_key(input logic [63:0] m);
		logic [63:0] k;
		if (m[62:0] == '0) k = 64'h8000_0000_0000_0000;
		else if (m[63]) k = ~m;
		else k = m | 64'h8000_0000_0000_0000;
		return k;
	endfunction

	function automatic logic should_replace(input logic [63:0] c, input logic [63:0] k,
			input cfg_t cfg);
		logic [63:0] cm, km, ck, kk;
		logic cn, kn, gt, lt;
		cm = '0;
		km = '0;
		cn = 1'b0;
		kn = 1'b0;
		if (cfg.elem_type == TYPE_F32) begin
			cm = {c[31], 32'd0, c[30:0]};
			km = {k[31], 32'd0, k[30:0]};
			cn = (c[30:23] == 8'hff) && (c[22:0] != '0);
			kn = (k[30:23] == 8'hff) && (k[22:0] != '0);
		end else if (cfg.elem_type == TYPE_F64) begin
			cm = c;
			km = k;
			cn = (c[62:52] == 11'h7ff) && (c[51:0] != '0);
			kn = (k[62:52] == 11'h7ff) && (k[51:0] != '0);
		end
		if (cfg.elem_type == TYPE_F32 || cfg.elem_type == TYPE_F64) begin
			ck = real_key(cm);
			kk = real_key(km);
			gt = ck > kk;
			lt = ck < kk;
			return cfg.find_max ? (cn || (!kn && gt)) : (kn || (!cn && lt));
		end
		ck = int_key(c, cfg.elem_type);
		kk = int_key(k, cfg.elem_type);
		return cfg.find_max ? (ck > kk) : (ck < kk);
	endfunction

endpackage

@@ sv/null_aware_array_min_max_reducer.sv @@
// top level of the null-aware array min/max reducer
// depends on namm_pkg, namm_cfg, namm_core
//
// usage:
//   input channel (in_valid/in_ready) carries one item per transfer: an array
//   element (action 0) or a null/empty row marker (action 1, 2; 3 acts as empty)
//   output channel (out_valid/out_ready) carries one result per row: the
//   max or min element (find_max register), or result_null for null, empty
//   or all-null rows
//   a result is registered in the output register once the last item of its
//   row has passed the input register and the output slot can take it
//   items are taken one per cycle unless stalled as below; one compare-and-select
//   on the running extreme sets the rate
//   a result waiting in the output register does not block intake; only an
//   item that would produce a second result stalls until out_ready
//   reset clears the running state and the output valid flag, and sets
//   find_max to 1 and element_type to int32
//   configuration is written through the apb-style port while idle
//   register 0 at address 0: find_max; register 1 at address 4: element_type
module null_aware_array_min_max_reducer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] value,
	input  logic        element_null,
	input  logic        last_in_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_value,
	output logic        result_null
);
	import namm_pkg::*;

	cfg_t  cfg;
	item_t item;

	// markers are folded into a single flag; unused code 3 behaves as empty
	assign item.value = value;
	assign item.is_null = element_null;
	assign item.last = last_in_row;
	assign item.marker = (action != ACT_ELEM);

	namm_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg)
	);

	namm_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(item),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_value(result_value), .out_null(result_null)
	);
endmodule

@@ sv/namm_cfg.sv @@
// configuration registers behind the apb-style port
// depends on namm_pkg
module namm_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:2]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output namm_pkg::cfg_t     cfg
);
	import namm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.find_max <= 1'b1;
			cfg_q.elem_type <= TYPE_I32;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_FIND_MAX: cfg_q.find_max <= pwdata[0];
				REG_ELEM_TYPE: cfg_q.elem_type <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FIND_MAX: prdata = {31'd0, cfg_q.find_max};
			default: prdata = {29'd0, cfg_q.elem_type};
		endcase
	end

	assign pready = 1'b1;
	assign cfg = cfg_q;
endmodule

@@ sv/namm_core.sv @@
// input register, compare-and-select stage and output register
// depends on namm_pkg
module namm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  namm_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  namm_pkg::item_t     in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         out_value,
	output logic                out_null
);
	import namm_pkg::*;

	item_t       item_s1;
	logic        valid_s1;
	logic        have_q;
	logic [63:0] best_q;
	logic        ovalid_q;
	logic [63:0] oval_q;
	logic        onull_q;
	logic        emit, adv, take;
	logic [63:0] mask, bits, best_nx;
	logic        have_nx;

	// stage 1 advances when the output slot is free or being read, or a result will not be made
	assign emit = valid_s1 && (item_s1.marker || item_s1.last);
	assign adv = valid_s1 && (!emit || !ovalid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign take = in_valid && in_ready;

	always_comb begin
		mask = type_mask(cfg.elem_type);
		bits = item_s1.value & mask;
		have_nx = have_q;
		best_nx = best_q;
		if (!item_s1.is_null) begin
			if (!have_q || should_replace(bits, best_q, cfg)) best_nx = bits;
			have_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			have_q <= 1'b0;
			best_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (adv && emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (take) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) begin
				if (emit) begin
					have_q <= 1'b0;
					best_q <= '0;
				end else begin
					have_q <= have_nx;
					best_q <= best_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_s1 <= in_item;
		if (adv && emit) begin
			if (item_s1.marker || !have_nx) begin
				oval_q <= '0;
				onull_q <= 1'b1;
			end else begin
				oval_q <= best_nx & mask;
				onull_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_value = oval_q;
	assign out_null = onull_q;
endmodule

@@ sv/namm_checker.sv @@
// port-level checks for the reducer
// depends on the top level ports only; bound below
module namm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_value,
	input logic        result_null,
	input logic        pready
);
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_null |-> result_value == 64'd0) else $error("null nonzero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value)) else $error("out hold");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind null_aware_array_min_max_reducer namm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.result_value(result_value), .result_null(result_null), .pready(pready)
);

@@ dv/tb_top.sv @@
// testbench for null_aware_array_min_max_reducer: random and directed rows of
// elements and row markers, checked against an in-bench row extreme predictor
// depends on namm_pkg for action, type and register codes
module tb_top;
	import namm_pkg::*;

	typedef struct {
		logic [1:0]  act;
		logic [63:0] val;
		logic        enull;
		logic        last;
	} elem_item_t;

	typedef struct {
		logic [63:0] val;
		logic        rnull;
	} row_result_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:2]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic [1:0]  action;
	logic [63:0] value;
	logic        element_null, last_in_row;
	logic        out_valid, out_ready;
	logic [63:0] result_value;
	logic        result_null;

	null_aware_array_min_max_reducer dut (.*);

	// predictor state and configuration copy
	logic        pred_max;
	logic [2:0]  pred_type;
	logic        row_has_value;
	logic [63:0] row_extreme;

	elem_item_t  pending_items[$];
	row_result_t expected_rows[$];

	int  send_idle_pct, recv_stall_pct;
	int  mismatches, rows_checked, items_sent;
	int  cycle_count;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// ---------------- predictor ----------------
	function automatic logic [63:0] width_bits(input logic [2:0] t);
		case (t)
			TYPE_I8:   return 64'hff;
			TYPE_I16:  return 64'hffff;
			TYPE_I32, TYPE_F32: return 64'hffff_ffff;
			TYPE_BOOL: return 64'h1;
			default:   return '1;
		endcase
	endfunction

	function automatic logic is_nan(input logic [63:0] b, input logic [2:0] t);
		if (t == TYPE_F32)
			return b[30:23] == 8'hff && b[22:0] != 0;
		return b[62:52] == 11'h7ff && b[51:0] != 0;
	endfunction

	// map a float bit pattern to an unsigned-orderable key, zeros equal
	function automatic logic [63:0] float_order(input logic [63:0] b, input logic [2:0] t);
		logic [63:0] sm;
		sm = (t == TYPE_F32) ? {b[31], 32'd0, b[30:0]} : b;
		if (sm[62:0] == 0) return 64'h8000_0000_0000_0000;
		if (sm[63]) return ~sm;
		return {1'b1, sm[62:0]};
	endfunction

	function automatic logic [63:0] signed_order(input logic [63:0] b, input logic [2:0] t);
		logic [63:0] v;
		case (t)
			TYPE_I8:   v = {{56{b[7]}}, b[7:0]};
			TYPE_I16:  v = {{48{b[15]}}, b[15:0]};
			TYPE_I32:  v = {{32{b[31]}}, b[31:0]};
			TYPE_BOOL: return {63'd0, b[0]};
			default:   v = b;
		endcase
		return {~v[63], v[62:0]};
	endfunction

	function automatic logic candidate_wins(input logic [63:0] c, input logic [63:0] k);
		logic cn, kn;
		logic [63:0] ck, kk;
		if (pred_type == TYPE_F32 || pred_type == TYPE_F64) begin
			cn = is_nan(c, pred_type);
			kn = is_nan(k, pred_type);
			ck = float_order(c, pred_type);
			kk = float_order(k, pred_type);
			return pred_max ? (cn || (!kn && ck > kk)) : (kn || (!cn && ck < kk));
		end
		ck = signed_order(c, pred_type);
		kk = signed_order(k, pred_type);
		return pred_max ? ck > kk : ck < kk;
	endfunction

	task automatic predict_row_step(input elem_item_t it);
		logic [63:0] bits;
		row_result_t r;
		if (it.act != ACT_ELEM) begin
			row_has_value = 0;
			row_extreme = 0;
			r.val = 0; r.rnull = 1;
			expected_rows.push_back(r);
			return;
		end
		if (!it.enull) begin
			bits = it.val & width_bits(pred_type);
			if (!row_has_value || candidate_wins(bits, row_extreme))
				row_extreme = bits;
			row_has_value = 1;
		end
		if (it.last) begin
			r.rnull = !row_has_value;
			r.val = row_has_value ? (row_extreme & width_bits(pred_type)) : 64'd0;
			expected_rows.push_back(r);
			row_has_value = 0;
			row_extreme = 0;
		end
	endtask

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			action <= 0; value <= 0; element_null <= 0; last_in_row <= 0;
		end else begin
			// transfer completes at this edge: feed predictor, drop item
			if (in_valid && in_ready) begin
				predict_row_step(pending_items.pop_front());
				items_sent++;
			end
			if ((!in_valid || in_ready)) begin
				if (pending_items.size() > (in_valid && in_ready ? 0 : 0) &&
						$urandom_range(99) >= send_idle_pct &&
						pending_items.size() != 0) begin
					in_valid <= 1;
					action <= pending_items[0].act;
					value <= pending_items[0].val;
					element_null <= pending_items[0].enull;
					last_in_row <= pending_items[0].last;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		row_result_t e;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				rows_checked++;
				if (expected_rows.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %h null %b",
							result_value, result_null);
				end else begin
					e = expected_rows.pop_front();
					if (e.val !== result_value || e.rnull !== result_null) begin
						mismatches++;
						if (mismatches <= 10)
							$display("row mismatch: expected %h/%b got %h/%b",
								e.val, e.rnull, result_value, result_null);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// timeout guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------- config access ----------------
	task automatic apb_write(input logic [0:0] reg_idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= reg_idx; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (reg_idx == REG_FIND_MAX) pred_max = data[0];
		else pred_type = data[2:0];
	endtask

	task automatic set_mode(input logic mx, input logic [2:0] t);
		apb_write(REG_FIND_MAX, {31'd0, mx});
		apb_write(REG_ELEM_TYPE, {29'd0, t});
	endtask

	// wait for queue and results to drain, plus pipeline latency
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic elem_item_t mk(input logic [1:0] a, input logic [63:0] v,
			input logic n, input logic l);
		elem_item_t it;
		it.act = a; it.val = v; it.enull = n; it.last = l;
		return it;
	endfunction

	// interesting per-type values: extremes, zeros, infinities and nans
	function automatic logic [63:0] pick_value(input logic [2:0] t);
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0: r = 0;
			1: r = '1;
			2: r = (t == TYPE_F32) ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
			3: r = (t == TYPE_F32) ? {r[63:32], 32'h7f80_0000 | r[22:0]} :
				{r[63], 11'h7ff, r[51:0]};
			4: r = (t == TYPE_F32) ? {r[63:32], r[31], 31'h7f80_0000} :
				{r[63], 11'h7ff, 52'd0};
			5: r = {r[63:8], 8'h80};
			6: r = {r[63:8], 8'h7f};
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_random_rows(input int n, input logic [2:0] t);
		int len, k;
		for (int i = 0; i < n; ) begin
			k = $urandom_range(19);
			if (k == 0) begin
				pending_items.push_back(mk(ACT_NULL, pick_value(t),
					1'($urandom_range(1)), 1'($urandom_range(1))));
				i++;
			end else if (k == 1) begin
				pending_items.push_back(mk(2'($urandom_range(2, 3)), pick_value(t),
					1'($urandom_range(1)), 1'($urandom_range(1))));
				i++;
			end else begin
				len = $urandom_range(1, 6);
				for (int j = 0; j < len; j++) begin
					// rare early marker breaks a row in the middle
					if (j > 0 && $urandom_range(30) == 0)
						pending_items.push_back(mk(ACT_EMPTY, 0, 0, 0));
					else
						pending_items.push_back(mk(ACT_ELEM, pick_value(t),
							$urandom_range(4) == 0, j == len - 1));
					i++;
				end
			end
		end
	endtask

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		mismatches = 0; rows_checked = 0; items_sent = 0; cycle_count = 0;
		pred_max = 1; pred_type = TYPE_I32;
		row_has_value = 0; row_extreme = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset mode int32 max, then markers, nulls, and extremes
		pending_items.push_back(mk(ACT_ELEM, 64'h0000_0000_8000_0000, 0, 0));
		pending_items.push_back(mk(ACT_ELEM, 64'hffff_ffff_7fff_ffff, 0, 1));
		pending_items.push_back(mk(ACT_NULL, 0, 0, 0));
		pending_items.push_back(mk(ACT_EMPTY, 0, 0, 1));
		pending_items.push_back(mk(2'd3, 0, 0, 0));
		pending_items.push_back(mk(ACT_ELEM, 5, 1, 0));
		pending_items.push_back(mk(ACT_ELEM, 7, 1, 1));
		pending_items.push_back(mk(ACT_ELEM, 9, 0, 0));
		pending_items.push_back(mk(ACT_NULL, 0, 0, 0));
		drain();
		set_mode(0, TYPE_F32);
		// min replaces a held nan, then equal zeros keep first
		pending_items.push_back(mk(ACT_ELEM, 64'h7fc0_0000, 0, 0));
		pending_items.push_back(mk(ACT_ELEM, 64'hbf80_0000, 0, 1));
		pending_items.push_back(mk(ACT_ELEM, 64'h8000_0000, 0, 0));
		pending_items.push_back(mk(ACT_ELEM, 64'h0000_0000, 0, 1));
		drain();
		set_mode(1, TYPE_F64);
		pending_items.push_back(mk(ACT_ELEM, 64'h7ff0_0000_0000_0000, 0, 0));
		pending_items.push_back(mk(ACT_ELEM, 64'hfff8_0000_0000_0001, 0, 1));
		drain();

		// random phases across modes, types and idle patterns
		for (int ph = 0; ph < 28; ph++) begin
			set_mode(ph[0], 3'((ph / 2) % 8));
			case ((ph / 2) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			queue_random_rows(50, 3'((ph / 2) % 8));
			drain();
		end

		$display("sent %0d items, checked %0d row results over 8 types and both modes",
			items_sent, rows_checked);
		if (mismatches == 0 && expected_rows.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end
endmodule
